/* design/ssw_pkg.sv */
// package for the spliced smith-waterman score block
// field widths, operation codes and register indexes; no dependencies
package ssw_pkg;

    localparam int MAX_READ_DEF = 256;
    localparam int MAX_DONORS_DEF = 64;
    localparam int MAX_JUNCTIONS_DEF = 8;

    localparam int OP_W = 2;
    localparam int BASE_W = 8;
    localparam int RLEN_W = 9;
    localparam int DNUM_W = 6;
    localparam int SCORE_W = 15;
    localparam int ROW_OUT_W = 8;
    localparam int COL_W = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 7;
    localparam int SCORE_CAP = 32767;

    localparam logic [OP_W-1:0] OP_START = 2'd0;
    localparam logic [OP_W-1:0] OP_READ = 2'd1;
    localparam logic [OP_W-1:0] OP_JUNCTION = 2'd2;
    localparam logic [OP_W-1:0] OP_COLUMN = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_MATCH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MISMATCH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAP = 2'd2;

endpackage

/* design/ssw_in_if.sv */
// input channel of the spliced smith-waterman score block
// depends on ssw_pkg for field widths
interface ssw_in_if;
    logic                          valid;
    logic                          ready;
    logic [ssw_pkg::OP_W-1:0]      op;
    logic [ssw_pkg::BASE_W-1:0]    base;
    logic [ssw_pkg::RLEN_W-1:0]    read_length;
    logic [ssw_pkg::DNUM_W-1:0]    donor_number;
    logic                          is_donor;
    logic                          last;

    modport source(output valid, op, base, read_length, donor_number, is_donor, last,
                   input ready);
    modport sink(input valid, op, base, read_length, donor_number, is_donor, last,
                 output ready);
endinterface

/* design/ssw_out_if.sv */
// result channel of the spliced smith-waterman score block
// depends on ssw_pkg for field widths
interface ssw_out_if;
    logic                            valid;
    logic                            ready;
    logic [ssw_pkg::SCORE_W-1:0]     best_score;
    logic [ssw_pkg::ROW_OUT_W-1:0]   end_row;
    logic [ssw_pkg::COL_W-1:0]       end_column;

    modport source(output valid, best_score, end_row, end_column, input ready);
    modport sink(input valid, best_score, end_row, end_column, output ready);
endinterface

/* design/spliced_smith_waterman_score.sv */
// spliced smith-waterman score fill, linear gap, junction jumps
// depends on ssw_pkg, ssw_in_if, ssw_out_if
//
//  channel   dir  handshake        payload
//  i_in      in   valid/ready      op, base, read_length, donor_number, is_donor, last
//  o_out     out  valid/ready      best_score, end_row, end_column
//  cfg       in   i_cfg_we         i_cfg_index, i_cfg_wdata
//
// start, read base and junction items are taken in the idle state
// a reference column walks its L read rows, each through an issue state and then a data state
// that handles its J junctions, set by the single read port of the donor memory, one junction read per cycle;
// a last column then passes through an emit state that loads the result register
// reset is synchronous and needs no clearing pass; the first column after start
// sees a zero previous column through a flag
// a finished result waits in an output register; the block keeps taking items
// and stalls only when a second result finds that register still full
module spliced_smith_waterman_score #(
    parameter int MAX_READ = ssw_pkg::MAX_READ_DEF,
    parameter int MAX_DONORS = ssw_pkg::MAX_DONORS_DEF,
    parameter int MAX_JUNCTIONS_PER_COLUMN = ssw_pkg::MAX_JUNCTIONS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    ssw_in_if.sink                           i_in,
    ssw_out_if.source                        o_out,
    input  logic                             i_cfg_we,
    input  logic [ssw_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [ssw_pkg::CFG_DATA_W-1:0]   i_cfg_wdata
);
    localparam int MJ = MAX_JUNCTIONS_PER_COLUMN;
    localparam int RW = $clog2(MAX_READ + 1);
    localparam int RIW = $clog2(MAX_READ);
    localparam int JW = $clog2(MJ + 1);
    localparam int JIW = (MJ > 1) ? $clog2(MJ) : 1;
    localparam int DCW = $clog2(MAX_DONORS + 1);
    localparam int DAW = (MAX_DONORS * MAX_READ > 1) ? $clog2(MAX_DONORS * MAX_READ) : 1;
    localparam int SW = ssw_pkg::SCORE_W;
    localparam int AW = SW + 3;

    typedef enum logic [1:0] {S_IDLE, S_ISSUE, S_DATA, S_EMIT} t_state;

    // memories
    logic [ssw_pkg::BASE_W-1:0] read_mem [MAX_READ];
    logic [SW-1:0]              work_mem [MAX_READ];
    logic [SW-1:0]              donor_mem [MAX_DONORS * MAX_READ];

    t_state                     r_state;
    logic [5:0]                 r_match;
    logic signed [6:0]          r_mismatch;
    logic signed [6:0]          r_gap;
    logic [RW-1:0]              r_len;
    logic [RW-1:0]              r_fill;
    logic [RW-1:0]              r_row;
    logic [JW-1:0]              r_jcnt;
    logic [JW-1:0]              r_k;
    logic [DCW-1:0]             r_dcnt;
    logic [ssw_pkg::COL_W-1:0]  r_col;
    logic [SW-1:0]              r_best;
    logic [RIW-1:0]             r_best_row;
    logic [ssw_pkg::COL_W-1:0]  r_best_col;
    logic                       r_prev_zero;
    logic [ssw_pkg::DNUM_W-1:0] r_pend [MJ];
    logic [SW-1:0]              r_up [MJ];
    logic [ssw_pkg::BASE_W-1:0] r_col_base;
    logic                       r_col_last;
    logic                       r_storing;
    logic [SW-1:0]              r_curm1;
    logic [SW-1:0]              r_prevm1;
    logic [AW-1:0]              r_acc;
    logic [ssw_pkg::BASE_W-1:0] r_rd_read;
    logic [SW-1:0]              r_rd_work;
    logic [SW-1:0]              r_rd_donor;
    logic                       r_out_valid;
    logic [SW-1:0]              r_out_score;
    logic [ssw_pkg::ROW_OUT_W-1:0] r_out_row;
    logic [ssw_pkg::COL_W-1:0]  r_out_col;

    logic                       in_xfer;
    logic [RIW-1:0]             rowm1;
    logic [JW-1:0]              iss_j;
    logic [DAW-1:0]             donor_raddr;
    logic [DAW-1:0]             donor_waddr;
    logic                       row_done;
    logic                       self_link;
    logic signed [AW-1:0]       c_sub, c_gap, c_prevr, c_acc, c_cand, c_up, c_dv;
    logic [SW-1:0]              n_cell;
    logic [31:0]                best_row_ext;
    logic [31:0]                len_sat;
    logic                       out_free;

    assign out_free = !r_out_valid || o_out.ready;
    assign i_in.ready = (r_state == S_IDLE);
    assign in_xfer = i_in.valid && i_in.ready;
    assign rowm1 = RIW'(r_row - RW'(1));
    assign iss_j = (r_state == S_ISSUE) ? JW'(0) : JW'(r_k + JW'(1));
    assign donor_raddr = DAW'(32'(r_pend[JIW'(iss_j)]) * MAX_READ + 32'(rowm1));
    assign donor_waddr = DAW'(32'(r_dcnt) * MAX_READ + 32'(rowm1));
    assign row_done = (JW'(r_k + JW'(1)) >= r_jcnt);
    assign len_sat = (32'(i_in.read_length) > MAX_READ) ? 32'(MAX_READ)
                                                        : 32'(i_in.read_length);
    assign self_link = r_storing && (9'(r_pend[JIW'(r_k)]) == 9'(r_dcnt));

    // cell score of the current row, one junction per cycle
    always_comb begin
        c_cand = '0;
        c_gap = AW'(r_gap);
        c_sub = (r_rd_read == r_col_base) ? $signed(AW'(r_match)) : AW'(r_mismatch);
        c_prevr = r_prev_zero ? '0 : $signed(AW'(r_rd_work));
        if (r_k == '0) begin
            c_acc = '0;
            c_cand = $signed(AW'(r_curm1)) + c_gap;
            if (c_cand > c_acc) c_acc = c_cand;
            c_cand = c_prevr + c_gap;
            if (c_cand > c_acc) c_acc = c_cand;
            c_cand = $signed(AW'(r_prevm1)) + c_sub;
            if (c_cand > c_acc) c_acc = c_cand;
        end else begin
            c_acc = $signed(r_acc);
        end
        c_dv = $signed(AW'(r_rd_donor));
        if (r_row == RW'(1)) c_up = '0;
        else if (self_link) c_up = $signed(AW'(r_curm1));
        else c_up = $signed(AW'(r_up[JIW'(r_k)]));
        if (r_k < r_jcnt) begin
            c_cand = c_dv + c_gap;
            if (c_cand > c_acc) c_acc = c_cand;
            c_cand = c_up + c_sub;
            if (c_cand > c_acc) c_acc = c_cand;
        end
        n_cell = (c_acc > AW'(ssw_pkg::SCORE_CAP)) ? SW'(ssw_pkg::SCORE_CAP)
                                                   : SW'(c_acc);
    end

    // memory ports
    always_ff @(posedge i_clk) begin
        if (in_xfer && i_in.op == ssw_pkg::OP_READ && 32'(r_fill) < MAX_READ) begin
            read_mem[RIW'(r_fill)] <= i_in.base;
        end
        if (r_state == S_DATA && row_done) begin
            work_mem[rowm1] <= n_cell;
            if (r_storing) donor_mem[donor_waddr] <= n_cell;
        end
        if (r_state == S_ISSUE) begin
            r_rd_read <= read_mem[rowm1];
            r_rd_work <= work_mem[rowm1];
        end
        r_rd_donor <= donor_mem[donor_raddr];
    end

    assign best_row_ext = 32'(r_best_row);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_match <= 6'd1;
            r_mismatch <= -7'sd1;
            r_gap <= -7'sd1;
            r_len <= '0;
            r_fill <= '0;
            r_row <= '0;
            r_jcnt <= '0;
            r_k <= '0;
            r_dcnt <= '0;
            r_col <= '0;
            r_best <= '0;
            r_best_row <= '0;
            r_best_col <= '0;
            r_prev_zero <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    ssw_pkg::REG_MATCH:    r_match <= i_cfg_wdata[5:0];
                    ssw_pkg::REG_MISMATCH: r_mismatch <= $signed(i_cfg_wdata);
                    ssw_pkg::REG_GAP:      r_gap <= $signed(i_cfg_wdata);
                    default: ;
                endcase
            end
            if (r_out_valid && o_out.ready && r_state != S_EMIT) r_out_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        case (i_in.op)
                            ssw_pkg::OP_START: begin
                                r_len <= RW'(len_sat);
                                r_jcnt <= '0;
                                r_dcnt <= '0;
                                r_col <= '0;
                                r_fill <= '0;
                                r_best <= '0;
                                r_best_row <= '0;
                                r_best_col <= '0;
                                r_prev_zero <= 1'b1;
                            end
                            ssw_pkg::OP_READ: begin
                                if (32'(r_fill) < MAX_READ) r_fill <= RW'(r_fill + RW'(1));
                            end
                            ssw_pkg::OP_JUNCTION: begin
                                if (32'(r_jcnt) < MJ && 32'(i_in.donor_number) < MAX_DONORS)
                                begin
                                    r_pend[JIW'(r_jcnt)] <= i_in.donor_number;
                                    r_jcnt <= JW'(r_jcnt + JW'(1));
                                end
                            end
                            default: begin
                                r_col_base <= i_in.base;
                                r_col_last <= i_in.last;
                                r_storing <= i_in.is_donor && (32'(r_dcnt) < MAX_DONORS);
                                r_curm1 <= '0;
                                r_prevm1 <= '0;
                                r_row <= RW'(1);
                                if (r_len == '0) begin
                                    // empty read: close the column at once
                                    r_jcnt <= '0;
                                    r_prev_zero <= 1'b0;
                                    r_col <= ssw_pkg::COL_W'(r_col + 1'b1);
                                    if (i_in.is_donor && 32'(r_dcnt) < MAX_DONORS)
                                        r_dcnt <= DCW'(r_dcnt + DCW'(1));
                                    if (i_in.last) r_state <= S_EMIT;
                                end else begin
                                    r_state <= S_ISSUE;
                                end
                            end
                        endcase
                    end
                end
                S_ISSUE: begin
                    r_k <= '0;
                    r_state <= S_DATA;
                end
                S_DATA: begin
                    r_acc <= AW'(c_acc);
                    if (r_k < r_jcnt) r_up[JIW'(r_k)] <= r_rd_donor;
                    r_k <= JW'(r_k + JW'(1));
                    if (row_done) begin
                        r_curm1 <= n_cell;
                        r_prevm1 <= SW'(c_prevr);
                        if (n_cell > r_best) begin
                            r_best <= n_cell;
                            r_best_row <= rowm1;
                            r_best_col <= r_col;
                        end
                        if (r_row == r_len) begin
                            r_jcnt <= '0;
                            r_prev_zero <= 1'b0;
                            r_col <= ssw_pkg::COL_W'(r_col + 1'b1);
                            if (r_storing) r_dcnt <= DCW'(r_dcnt + DCW'(1));
                            r_state <= r_col_last ? S_EMIT : S_IDLE;
                        end else begin
                            r_row <= RW'(r_row + RW'(1));
                            r_state <= S_ISSUE;
                        end
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_score <= r_best;
                        r_out_row <= best_row_ext[ssw_pkg::ROW_OUT_W-1:0];
                        r_out_col <= r_best_col;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.best_score = r_out_score;
    assign o_out.end_row = r_out_row;
    assign o_out.end_column = r_out_col;

endmodule

/* design/ssw_checker.sv */
// port-level checks for the spliced smith-waterman score block
// depends on ssw_pkg; bound to spliced_smith_waterman_score
module ssw_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_in_valid,
    input logic                            i_in_ready,
    input logic                            i_out_valid,
    input logic                            i_out_ready,
    input logic [ssw_pkg::SCORE_W-1:0]     i_score,
    input logic [ssw_pkg::ROW_OUT_W-1:0]   i_row,
    input logic [ssw_pkg::COL_W-1:0]       i_col
);
    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_score)
            && $stable(i_row) && $stable(i_col))
        else $error("stalled result changed");

    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid && i_in_ready)
        else $error("not quiet after reset");

    // a zero score has no end cell
    a_zero_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_score == '0 |-> i_row == '0 && i_col == '0)
        else $error("zero score with nonzero position");

    // a new result is loaded while the input side is busy
    a_out_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> !$past(i_in_ready))
        else $error("result without cause");
endmodule

bind spliced_smith_waterman_score ssw_checker u_ssw_checker (
    .i_clk(i_clk),
    .i_rst_n(i_rst_n),
    .i_in_valid(i_in.valid),
    .i_in_ready(i_in.ready),
    .i_out_valid(o_out.valid),
    .i_out_ready(o_out.ready),
    .i_score(o_out.best_score),
    .i_row(o_out.end_row),
    .i_col(o_out.end_column)
);

/* sim/tb_top.sv */
// self-checking testbench for spliced_smith_waterman_score
// depends on ssw_pkg, ssw_in_if, ssw_out_if and the block itself
// directed table, then random alignments checked against a score-fill predictor
module tb_top;
    import ssw_pkg::*;

    localparam int READ_DEPTH = 256;
    localparam int DONOR_SLOTS = 64;
    localparam int JUNC_SLOTS = 8;
    localparam int DRAIN_CYCLES = 2400;
    localparam int STALL_LIMIT = 20000;
    localparam int HOLD_CYCLES = 3000;

    typedef struct {
        logic [OP_W-1:0]   op;
        logic [BASE_W-1:0] base;
        logic [RLEN_W-1:0] read_length;
        logic [DNUM_W-1:0] donor_number;
        logic              is_donor;
        logic              last;
    } align_item_t;

    typedef struct {
        logic [SCORE_W-1:0]   best_score;
        logic [ROW_OUT_W-1:0] end_row;
        logic [COL_W-1:0]     end_column;
    } align_score_t;

    typedef struct {
        int op, base, rlen, dnum, isd, last, chk, es, er, ec;
    } dir_row_t;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;

    ssw_in_if  in_ch();
    ssw_out_if out_ch();

    spliced_smith_waterman_score dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch.sink), .o_out(out_ch.source),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_wdata(i_cfg_wdata)
    );

    // predictor state
    int match_val, mismatch_val, gap_val;
    logic [BASE_W-1:0] read_mem [READ_DEPTH];
    int prev_col [READ_DEPTH+1];
    int cur_col [READ_DEPTH+1];
    int donor_mem [DONOR_SLOTS*READ_DEPTH];
    int donor_rows [DONOR_SLOTS];
    int junc_list [JUNC_SLOTS];
    int junc_count, donor_count, active_len, fill_ptr, read_rows_written;
    logic [COL_W-1:0] col_count;
    int best_val, best_r, best_c;

    align_score_t score_q [$];
    int err_count;
    bit quiet;
    bit hold_req;
    int idle_cycles;

    dir_row_t dir_tab [19] = '{
        '{OP_COLUMN, 9, 0, 0, 0, 1, 1, 0, 0, 0},
        '{OP_START, 0, 2, 0, 0, 0, 0, 0, 0, 0},
        '{OP_READ, 5, 0, 0, 0, 0, 0, 0, 0, 0},
        '{OP_READ, 7, 0, 0, 0, 0, 0, 0, 0, 0},
        '{OP_COLUMN, 5, 0, 0, 0, 1, 1, 1, 0, 0},
        '{OP_COLUMN, 7, 0, 0, 1, 1, 1, 2, 1, 1},
        '{OP_JUNCTION, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{OP_COLUMN, 7, 0, 0, 0, 1, 0, 0, 0, 0},
        '{OP_JUNCTION, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{OP_JUNCTION, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{OP_COLUMN, 255, 0, 0, 1, 1, 0, 0, 0, 0},
        '{OP_START, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{OP_COLUMN, 0, 0, 0, 0, 1, 1, 0, 0, 0},
        '{OP_START, 0, 3, 0, 0, 0, 0, 0, 0, 0},
        '{OP_READ, 255, 0, 0, 0, 0, 0, 0, 0, 0},
        '{OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{OP_READ, 128, 0, 0, 0, 0, 0, 0, 0, 0},
        '{OP_COLUMN, 255, 0, 0, 0, 1, 1, 1, 0, 0},
        '{OP_COLUMN, 128, 0, 0, 1, 1, 0, 0, 0, 0}
    };

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // row 0 of every stored donor is the zero boundary
    function automatic int donor_at(int d, int r);
        if (r == 0) return 0;
        return donor_mem[d*READ_DEPTH + r - 1];
    endfunction

    task automatic fill_column(input align_item_t it, output bit has_res,
                               output align_score_t res);
        bit storing;
        int slot, sub, b, d;
        storing = it.is_donor && donor_count < DONOR_SLOTS;
        slot = donor_count;
        cur_col[0] = 0;
        for (int r = 1; r <= active_len; r++) begin
            sub = (read_mem[r-1] == it.base) ? match_val : mismatch_val;
            b = 0;
            if (cur_col[r-1] + gap_val > b) b = cur_col[r-1] + gap_val;
            if (prev_col[r] + gap_val > b) b = prev_col[r] + gap_val;
            if (prev_col[r-1] + sub > b) b = prev_col[r-1] + sub;
            for (int j = 0; j < junc_count; j++) begin
                d = junc_list[j];
                // self link: same row still holds the old store, row above the new one
                if (donor_at(d, r) + gap_val > b) b = donor_at(d, r) + gap_val;
                if (donor_at(d, r-1) + sub > b) b = donor_at(d, r-1) + sub;
            end
            if (b > SCORE_CAP) b = SCORE_CAP;
            cur_col[r] = b;
            if (storing) donor_mem[slot*READ_DEPTH + r - 1] = b;
            if (b > best_val) begin
                best_val = b;
                best_r = r - 1;
                best_c = col_count;
            end
        end
        prev_col = cur_col;
        if (storing) begin
            donor_count++;
            if (active_len > donor_rows[slot]) donor_rows[slot] = active_len;
        end
        junc_count = 0;
        col_count = col_count + 1'b1;
        has_res = it.last;
        res.best_score = best_val[SCORE_W-1:0];
        res.end_row = best_r[ROW_OUT_W-1:0];
        res.end_column = best_c[COL_W-1:0];
    endtask

    task automatic predict_item(input align_item_t it, input bit chk,
                                input align_score_t typed);
        bit has_res;
        align_score_t res;
        case (it.op)
            OP_START: begin
                active_len = (it.read_length > READ_DEPTH) ? READ_DEPTH : it.read_length;
                foreach (prev_col[i]) prev_col[i] = 0;
                foreach (cur_col[i]) cur_col[i] = 0;
                junc_count = 0;
                donor_count = 0;
                col_count = '0;
                fill_ptr = 0;
                best_val = 0;
                best_r = 0;
                best_c = 0;
            end
            OP_READ: begin
                if (fill_ptr < READ_DEPTH) begin
                    read_mem[fill_ptr] = it.base;
                    fill_ptr++;
                    if (fill_ptr > read_rows_written) read_rows_written = fill_ptr;
                end
            end
            OP_JUNCTION: begin
                if (junc_count < JUNC_SLOTS && it.donor_number < DONOR_SLOTS) begin
                    junc_list[junc_count] = it.donor_number;
                    junc_count++;
                end
            end
            default: begin
                fill_column(it, has_res, res);
                if (has_res) score_q.insert(score_q.size(), chk ? typed : res);
            end
        endcase
    endtask

    task automatic send(input align_item_t it, input bit chk = 1'b0,
                        input align_score_t typed = '{default: '0});
        if (!quiet && $urandom_range(0, 4) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.op <= it.op;
        in_ch.base <= it.base;
        in_ch.read_length <= it.read_length;
        in_ch.donor_number <= it.donor_number;
        in_ch.is_donor <= it.is_donor;
        in_ch.last <= it.last;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        predict_item(it, chk, typed);
    endtask

    function automatic align_item_t noise_item(logic [OP_W-1:0] op);
        align_item_t it;
        it.op = op;
        it.base = BASE_W'($urandom_range(0, 255));
        it.read_length = RLEN_W'($urandom_range(0, 511));
        it.donor_number = DNUM_W'($urandom_range(0, 63));
        it.is_donor = 1'($urandom_range(0, 1));
        it.last = 1'($urandom_range(0, 1));
        return it;
    endfunction

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (score_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_regs(input int m, input int mm, input int g);
        logic [CFG_IDX_W-1:0] idx [3];
        int vals [3];
        idx = '{REG_MATCH, REG_MISMATCH, REG_GAP};
        vals = '{m, mm, g};
        for (int i = 0; i < 3; i++) begin
            i_cfg_we <= 1'b1;
            i_cfg_index <= idx[i];
            i_cfg_wdata <= CFG_DATA_W'(vals[i]);
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        match_val = m;
        mismatch_val = mm;
        gap_val = g;
    endtask

    // junctions only name donors whose stored rows cover the whole read
    task automatic send_junctions(input int n);
        align_item_t it;
        int d;
        for (int k = 0; k < n; k++) begin
            d = -1;
            for (int t = 0; t < 12 && d < 0; t++) begin
                it.donor_number = DNUM_W'($urandom_range(0, 63));
                if (donor_rows[it.donor_number] >= active_len) d = it.donor_number;
            end
            if (d >= 0) begin
                it = noise_item(OP_JUNCTION);
                it.donor_number = DNUM_W'(d);
                send(it);
            end
        end
    endtask

    task automatic run_alignment(input int rlen, input int ncols, input int donor_pct,
                                 input bit noisy);
        align_item_t it;
        bit wide;
        int nbases;
        wide = ($urandom_range(0, 3) == 0);
        it = noise_item(OP_START);
        it.read_length = RLEN_W'(rlen);
        send(it);
        nbases = (rlen > READ_DEPTH) ? READ_DEPTH + $urandom_range(1, 4) : rlen;
        if (noisy && $urandom_range(0, 3) == 0) nbases += $urandom_range(1, 3);
        for (int i = 0; i < nbases; i++) begin
            it = noise_item(OP_READ);
            if (!wide) it.base = BASE_W'($urandom_range(0, 3));
            send(it);
        end
        for (int c = 0; c < ncols; c++) begin
            if (noisy && $urandom_range(0, 7) == 0) send_junctions($urandom_range(9, 10));
            else send_junctions($urandom_range(0, 3));
            if (noisy && $urandom_range(0, 9) == 0) begin
                it = noise_item(OP_READ);
                send(it);
            end
            if (read_rows_written >= active_len) begin
                it = noise_item(OP_COLUMN);
                if (!wide) it.base = BASE_W'($urandom_range(0, 3));
                it.is_donor = ($urandom_range(0, 99) < donor_pct);
                it.last = (c == ncols - 1) || ($urandom_range(0, 3) == 0);
                send(it);
            end
        end
    endtask

    task automatic random_phase(input int n_align);
        for (int a = 0; a < n_align; a++)
            run_alignment($urandom_range(1, 12), $urandom_range(2, 10), 50,
                          $urandom_range(0, 3) == 0);
    endtask

    // result side: random stalls and one long hold-off on request
    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                if (score_q.size() == 0) begin
                    $error("result transfer with nothing expected");
                    err_count++;
                end else begin
                    if (out_ch.best_score !== score_q[0].best_score) begin
                        $error("best_score expected %0d got %0d",
                               score_q[0].best_score, out_ch.best_score);
                        err_count++;
                    end
                    if (out_ch.end_row !== score_q[0].end_row) begin
                        $error("end_row expected %0d got %0d",
                               score_q[0].end_row, out_ch.end_row);
                        err_count++;
                    end
                    if (out_ch.end_column !== score_q[0].end_column) begin
                        $error("end_column expected %0d got %0d",
                               score_q[0].end_column, out_ch.end_column);
                        err_count++;
                    end
                    void'(score_q.pop_front());
                end
            end
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles > STALL_LIMIT) begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    initial begin
        align_item_t it;
        align_score_t ex;
        err_count = 0;
        idle_cycles = 0;
        quiet = 1'b0;
        hold_req = 1'b0;
        match_val = 1;
        mismatch_val = -1;
        gap_val = -1;
        foreach (donor_rows[i]) donor_rows[i] = 0;
        foreach (prev_col[i]) prev_col[i] = 0;
        foreach (cur_col[i]) cur_col[i] = 0;
        junc_count = 0;
        donor_count = 0;
        active_len = 0;
        fill_ptr = 0;
        read_rows_written = 0;
        col_count = '0;
        best_val = 0;
        best_r = 0;
        best_c = 0;
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_wdata <= '0;
        in_ch.valid <= 1'b0;
        in_ch.op <= OP_START;
        in_ch.base <= '0;
        in_ch.read_length <= '0;
        in_ch.donor_number <= '0;
        in_ch.is_donor <= 1'b0;
        in_ch.last <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_tab[i]) begin
            it.op = OP_W'(dir_tab[i].op);
            it.base = BASE_W'(dir_tab[i].base);
            it.read_length = RLEN_W'(dir_tab[i].rlen);
            it.donor_number = DNUM_W'(dir_tab[i].dnum);
            it.is_donor = 1'(dir_tab[i].isd);
            it.last = 1'(dir_tab[i].last);
            ex.best_score = SCORE_W'(dir_tab[i].es);
            ex.end_row = ROW_OUT_W'(dir_tab[i].er);
            ex.end_column = COL_W'(dir_tab[i].ec);
            send(it, 1'(dir_tab[i].chk), ex);
        end
        drain();

        set_regs(63, -63, -63);
        random_phase(3);
        // long read, saturated length
        run_alignment($urandom_range(257, 511), 3, 100, 1'b0);
        drain();

        set_regs(0, 0, 0);
        random_phase(2);
        drain();

        set_regs(63, 0, -63);
        // many donors: every donor number becomes usable, extra donors ignored
        run_alignment(2, 70, 100, 1'b1);
        random_phase(2);
        // sender keeps offering finished columns while results are held off
        hold_req = 1'b1;
        run_alignment(2, 6, 0, 1'b0);
        for (int c = 0; c < 5; c++) begin
            it = noise_item(OP_COLUMN);
            it.last = 1'b1;
            send(it);
        end
        drain();

        set_regs($urandom_range(0, 63), -$urandom_range(0, 63), -$urandom_range(0, 63));
        random_phase(2);
        drain();

        set_regs($urandom_range(0, 63), -$urandom_range(0, 63), -$urandom_range(0, 63));
        quiet = 1'b1;
        random_phase(2);
        drain();

        if (err_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule
